### design/dbgk_pkg.sv
package dbgk_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NDIR      = 9;
  localparam int POP_W     = 18;
  localparam int RHO_W     = 22;
  localparam int MOM_W     = 21;
  localparam int VEL_W     = 17;
  localparam int DEN_W     = 18;
  localparam int RATE_W    = 17;
  localparam int UU_W      = 35;
  localparam int QUO_BITS  = 18;
  localparam int DIV_W     = 40;

  localparam logic [RATE_W-1:0] RATE_RESET = 17'd128503;

  // Pipeline stage numbers, counted in clock edges after an item is taken.
  localparam int ST_LANE_IN  = 22;
  localparam int ST_LANE_OUT = 30;
  localparam int ST_OUT      = 31;

  // Rounded-up 2^32 / 9, used to divide by nine with one correction step.
  localparam logic signed [30:0] RECIP9 = 31'sd477218589;

  localparam logic signed [VEL_W-1:0] VEL_MAX = 17'sd65535;
  localparam logic signed [VEL_W-1:0] VEL_MIN = -17'sd65536;

  typedef logic signed [POP_W-1:0] pop_t;
  typedef logic signed [RHO_W-1:0] rho_t;
  typedef logic signed [MOM_W-1:0] mom_t;
  typedef logic signed [VEL_W-1:0] vel_t;
  typedef logic signed [UU_W-1:0]  uu_t;
  typedef logic [DEN_W-1:0]        den_t;
  typedef logic [RATE_W-1:0]       rate_t;
  typedef logic [3:0]              dir_idx_t;
  typedef logic signed [1:0]       dir_t;
  typedef pop_t                    pops_t [NDIR];

  function automatic dir_t dir_x(input dir_idx_t idx);
    dir_t r;
    case (idx)
      4'd1, 4'd5, 4'd8: r = 2'sd1;
      4'd3, 4'd6, 4'd7: r = -2'sd1;
      default:          r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic dir_t dir_y(input dir_idx_t idx);
    dir_t r;
    case (idx)
      4'd2, 4'd5, 4'd6: r = 2'sd1;
      4'd4, 4'd7, 4'd8: r = -2'sd1;
      default:          r = 2'sd0;
    endcase
    return r;
  endfunction

  // Weight 16/36, 4/36 or 1/36 folded into a right shift before the divide by nine.
  function automatic logic [4:0] weight_shift(input dir_idx_t idx);
    logic [4:0] r;
    case (idx)
      4'd0:                      r = 5'd14;
      4'd1, 4'd2, 4'd3, 4'd4:    r = 5'd16;
      default:                   r = 5'd18;
    endcase
    return r;
  endfunction

  function automatic pop_t sat_pop(input logic signed [32:0] v);
    pop_t r;
    if (v > 33'sd131071) begin
      r = 18'sd131071;
    end else if (v < -33'sd131072) begin
      r = -18'sd131072;
    end else begin
      r = v[POP_W-1:0];
    end
    return r;
  endfunction

endpackage

### design/dbgk_div.sv
module dbgk_div
  import dbgk_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  mom_t num,
  input  rho_t den,
  output vel_t quo
);

  logic [RHO_W-1:0]    d_abs;
  logic [MOM_W-1:0]    a_abs;
  logic [DIV_W-1:0]    n_r [QUO_BITS+1];
  logic [RHO_W-1:0]    d_r [QUO_BITS+1];
  logic [QUO_BITS-1:0] q_r [QUO_BITS+1];
  logic                neg_r [QUO_BITS+1];
  logic                zero_r [QUO_BITS+1];
  logic                big_r [QUO_BITS+1];
  logic [QUO_BITS:0]   mag;
  vel_t                quo_nxt;
  vel_t                quo_r;

  always_comb begin
    d_abs = den[RHO_W-1] ? RHO_W'(-den) : RHO_W'(den);
    a_abs = num[MOM_W-1] ? MOM_W'(-num) : MOM_W'(num);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]    <= DIV_W'({a_abs, 16'b0});
      d_r[0]    <= d_abs;
      q_r[0]    <= '0;
      neg_r[0]  <= num[MOM_W-1] ^ den[RHO_W-1];
      zero_r[0] <= (den == '0);
      big_r[0]  <= (24'(a_abs) >= {d_abs, 2'b00});
    end
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
    logic [DIV_W-1:0] trial;
    logic             ge;
    always_comb begin
      trial = DIV_W'(d_r[k]) << (QUO_BITS - 1 - k);
      ge    = (n_r[k] >= trial);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k+1]    <= ge ? n_r[k] - trial : n_r[k];
        q_r[k+1]    <= {q_r[k][QUO_BITS-2:0], ge};
        d_r[k+1]    <= d_r[k];
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
        big_r[k+1]  <= big_r[k];
      end
    end
  end

  always_comb begin
    mag = (QUO_BITS+1)'(q_r[QUO_BITS]) + (QUO_BITS+1)'(n_r[QUO_BITS] != '0);
    if (zero_r[QUO_BITS]) begin
      quo_nxt = '0;
    end else if (!neg_r[QUO_BITS]) begin
      if (big_r[QUO_BITS] || q_r[QUO_BITS] > 18'd65535) begin
        quo_nxt = VEL_MAX;
      end else begin
        quo_nxt = VEL_W'(q_r[QUO_BITS]);
      end
    end else begin
      if (big_r[QUO_BITS] || mag > 19'd65536) begin
        quo_nxt = VEL_MIN;
      end else begin
        quo_nxt = VEL_W'(-$signed({1'b0, mag}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

### design/dbgk_lane.sv
module dbgk_lane
  import dbgk_pkg::*;
(
  input  logic     clk,
  input  logic     en,
  input  dir_idx_t lane_idx,
  input  rate_t    relax,
  input  vel_t     ux,
  input  vel_t     uy,
  input  uu_t      uu,
  input  rho_t     rho,
  input  pop_t     f,
  input  logic     solid,
  output pop_t     post
);

  dir_t              dx, dy;
  logic [4:0]        sh;
  logic signed [18:0] ux_e, uy_e, tx, ty;

  logic signed [18:0] eu1_r;
  uu_t                uu1_r, uu2_r;
  rho_t               rho1_r, rho2_r, rho3_r;
  pop_t               f1_r, f2_r, f3_r, f4_r, f5_r, f6_r, f7_r;
  logic               s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r;
  logic signed [18:0] eu2_r;
  logic signed [35:0] sq2_r;
  logic signed [40:0] poly;
  logic signed [23:0] p3_r;
  logic signed [45:0] prod4_r;
  logic signed [31:0] t_c, t5_r;
  logic signed [61:0] m5_r;
  logic signed [29:0] q0;
  logic signed [33:0] rem9;
  logic signed [29:0] feq6_r;
  logic signed [30:0] diff;
  logic signed [47:0] pr7_r;
  logic signed [32:0] sum8;
  pop_t               post_r;

  always_comb begin
    dx   = dir_x(lane_idx);
    dy   = dir_y(lane_idx);
    sh   = weight_shift(lane_idx);
    ux_e = 19'(ux);
    uy_e = 19'(uy);
    tx   = (dx > 2'sd0) ? ux_e : ((dx < 2'sd0) ? -ux_e : 19'sd0);
    ty   = (dy > 2'sd0) ? uy_e : ((dy < 2'sd0) ? -uy_e : 19'sd0);
    poly = (41'sd1 <<< 33) + ((41'(eu2_r) * 41'sd6) <<< 16)
         + 41'sd9 * 41'(sq2_r) - 41'sd3 * 41'(uu2_r);
    t_c  = 32'(prod4_r >>> sh);
    q0   = 30'(m5_r >>> 32);
    rem9 = 34'(t5_r) - 34'(q0) * 34'sd9;
    diff = 31'(feq6_r) - 31'(f6_r);
    sum8 = 33'(f7_r) + 33'(pr7_r >>> 16);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eu1_r   <= tx + ty;
      uu1_r   <= uu;
      rho1_r  <= rho;
      f1_r    <= f;
      s1_r    <= solid;

      eu2_r   <= eu1_r;
      sq2_r   <= 36'(eu1_r) * 36'(eu1_r);
      uu2_r   <= uu1_r;
      rho2_r  <= rho1_r;
      f2_r    <= f1_r;
      s2_r    <= s1_r;

      p3_r    <= 24'(poly >>> 17);
      rho3_r  <= rho2_r;
      f3_r    <= f2_r;
      s3_r    <= s2_r;

      prod4_r <= 46'(rho3_r) * 46'(p3_r);
      f4_r    <= f3_r;
      s4_r    <= s3_r;

      t5_r    <= t_c;
      m5_r    <= 62'(t_c) * 62'(RECIP9);
      f5_r    <= f4_r;
      s5_r    <= s4_r;

      feq6_r  <= (rem9 >= 34'sd9) ? q0 + 30'sd1 : q0;
      f6_r    <= f5_r;
      s6_r    <= s5_r;

      pr7_r   <= 48'($signed({1'b0, relax})) * 48'(diff);
      f7_r    <= f6_r;
      s7_r    <= s6_r;

      post_r  <= s7_r ? f7_r : sat_pop(sum8);
    end
  end

  assign post = post_r;

endmodule

### design/d2q9_bgk_node_collision.sv
// D2Q9 BGK collision for one lattice node per item.
// The input channel (in_valid/in_ready) carries the nine populations of a
// node and its solid flag. The result channel (out_valid/out_ready) returns
// the nine relaxed populations with the density and the velocity.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) writes the
// relaxation rate; it is always ready and should be written while idle.
// One item is accepted per cycle unless the receiver stalls. Each item
// passes through the velocity divider, which resolves one quotient bit per
// stage over 18 stages, followed by the eight-stage equilibrium lanes, one
// per direction, and the output register.
// When the receiver stalls, the whole pipeline holds and in_ready drops
// until the waiting result is taken, so nothing is lost or repeated.
// Reset clears all valid flags and loads the default relaxation rate.
module d2q9_bgk_node_collision
  import dbgk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pop_t        in_pop_rest,
  input  pop_t        in_pop_east,
  input  pop_t        in_pop_north,
  input  pop_t        in_pop_west,
  input  pop_t        in_pop_south,
  input  pop_t        in_pop_northeast,
  input  pop_t        in_pop_northwest,
  input  pop_t        in_pop_southwest,
  input  pop_t        in_pop_southeast,
  input  logic        in_is_solid,
  output logic        out_valid,
  input  logic        out_ready,
  output pop_t        out_post_rest,
  output pop_t        out_post_east,
  output pop_t        out_post_north,
  output pop_t        out_post_west,
  output pop_t        out_post_south,
  output pop_t        out_post_northeast,
  output pop_t        out_post_northwest,
  output pop_t        out_post_southwest,
  output pop_t        out_post_southeast,
  output den_t        out_density,
  output vel_t        out_velocity_x,
  output vel_t        out_velocity_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  rate_t       cfg_data
);

  logic               adv;
  logic [ST_OUT:1]    v_r;
  rate_t              relax_r;
  pops_t              pin;
  rho_t               rho_c;
  mom_t               mx_c, my_c;
  mom_t               mx1_r, my1_r;
  pops_t              f_dly_r [1:ST_LANE_IN];
  rho_t               rho_dly_r [1:ST_LANE_OUT];
  logic               solid_dly_r [1:ST_LANE_OUT];
  vel_t               ux_div, uy_div;
  vel_t               vx_dly_r [ST_LANE_IN:ST_LANE_OUT];
  vel_t               vy_dly_r [ST_LANE_IN:ST_LANE_OUT];
  uu_t                uu_r;
  pops_t              post;
  pops_t              post_r;
  den_t               den_r;
  vel_t               velx_r, vely_r;
  rho_t               rho_l;
  logic               sol_l;

  assign adv       = !v_r[ST_OUT] || out_ready;
  assign in_ready  = adv;
  assign out_valid = v_r[ST_OUT];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      relax_r <= RATE_RESET;
    end else begin
      if (adv) begin
        v_r <= {v_r[ST_OUT-1:1], in_valid};
      end
      if (cfg_valid) begin
        relax_r <= cfg_data;
      end
    end
  end

  always_comb begin
    pin[0] = in_pop_rest;
    pin[1] = in_pop_east;
    pin[2] = in_pop_north;
    pin[3] = in_pop_west;
    pin[4] = in_pop_south;
    pin[5] = in_pop_northeast;
    pin[6] = in_pop_northwest;
    pin[7] = in_pop_southwest;
    pin[8] = in_pop_southeast;
    rho_c  = '0;
    mx_c   = '0;
    my_c   = '0;
    for (int k = 0; k < NDIR; k++) begin
      rho_c = rho_c + RHO_W'(pin[k]);
      if (dir_x(4'(k)) > 2'sd0) begin
        mx_c = mx_c + MOM_W'(pin[k]);
      end else if (dir_x(4'(k)) < 2'sd0) begin
        mx_c = mx_c - MOM_W'(pin[k]);
      end
      if (dir_y(4'(k)) > 2'sd0) begin
        my_c = my_c + MOM_W'(pin[k]);
      end else if (dir_y(4'(k)) < 2'sd0) begin
        my_c = my_c - MOM_W'(pin[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mx1_r          <= mx_c;
      my1_r          <= my_c;
      f_dly_r[1]     <= pin;
      rho_dly_r[1]   <= rho_c;
      solid_dly_r[1] <= in_is_solid;
      for (int s = 2; s <= ST_LANE_IN; s++) begin
        f_dly_r[s] <= f_dly_r[s-1];
      end
      for (int s = 2; s <= ST_LANE_OUT; s++) begin
        rho_dly_r[s]   <= rho_dly_r[s-1];
        solid_dly_r[s] <= solid_dly_r[s-1];
      end
      vx_dly_r[ST_LANE_IN] <= ux_div;
      vy_dly_r[ST_LANE_IN] <= uy_div;
      for (int s = ST_LANE_IN + 1; s <= ST_LANE_OUT; s++) begin
        vx_dly_r[s] <= vx_dly_r[s-1];
        vy_dly_r[s] <= vy_dly_r[s-1];
      end
      uu_r <= UU_W'(34'(ux_div) * 34'(ux_div)) + UU_W'(34'(uy_div) * 34'(uy_div));
    end
  end

  dbgk_div u_div_x (
    .clk (clk),
    .en  (adv),
    .num (mx1_r),
    .den (rho_dly_r[1]),
    .quo (ux_div)
  );

  dbgk_div u_div_y (
    .clk (clk),
    .en  (adv),
    .num (my1_r),
    .den (rho_dly_r[1]),
    .quo (uy_div)
  );

  for (genvar k = 0; k < NDIR; k++) begin : g_lane
    dbgk_lane u_lane (
      .clk      (clk),
      .en       (adv),
      .lane_idx (4'(k)),
      .relax    (relax_r),
      .ux       (vx_dly_r[ST_LANE_IN]),
      .uy       (vy_dly_r[ST_LANE_IN]),
      .uu       (uu_r),
      .rho      (rho_dly_r[ST_LANE_IN]),
      .f        (f_dly_r[ST_LANE_IN][k]),
      .solid    (solid_dly_r[ST_LANE_IN]),
      .post     (post[k])
    );
  end

  assign rho_l = rho_dly_r[ST_LANE_OUT];
  assign sol_l = solid_dly_r[ST_LANE_OUT];

  always_ff @(posedge clk) begin
    if (adv) begin
      post_r <= post;
      if (sol_l) begin
        den_r  <= DEN_W'(1 << FRAC_BITS);
        velx_r <= '0;
        vely_r <= '0;
      end else begin
        if (rho_l < 0) begin
          den_r <= '0;
        end else if (rho_l > 22'sd262143) begin
          den_r <= '1;
        end else begin
          den_r <= rho_l[DEN_W-1:0];
        end
        velx_r <= vx_dly_r[ST_LANE_OUT];
        vely_r <= vy_dly_r[ST_LANE_OUT];
      end
    end
  end

  assign out_post_rest      = post_r[0];
  assign out_post_east      = post_r[1];
  assign out_post_north     = post_r[2];
  assign out_post_west      = post_r[3];
  assign out_post_south     = post_r[4];
  assign out_post_northeast = post_r[5];
  assign out_post_northwest = post_r[6];
  assign out_post_southwest = post_r[7];
  assign out_post_southeast = post_r[8];
  assign out_density        = den_r;
  assign out_velocity_x     = velx_r;
  assign out_velocity_y     = vely_r;

endmodule

### dv/d2q9_bgk_node_collision_test.sv
module d2q9_bgk_node_collision_test;
  import dbgk_pkg::*;

  localparam int LATENCY = 31;

  typedef struct {
    pop_t pops [NDIR];
    logic solid;
  } node_t;

  typedef struct {
    pop_t post [NDIR];
    den_t den;
    vel_t vx;
    vel_t vy;
  } relaxed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pop_t in_pop [NDIR];
  logic in_is_solid = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  pop_t out_post [NDIR];
  den_t out_density;
  vel_t out_velocity_x;
  vel_t out_velocity_y;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  rate_t cfg_data = '0;

  rate_t omega = RATE_RESET;
  relaxed_t expected_q [$];
  int errors = 0;
  int burst_left = 0;
  int hold_cycles = 0;
  bit stall_mode = 0;

  initial begin
    for (int k = 0; k < NDIR; k++) in_pop[k] = '0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  d2q9_bgk_node_collision dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pop_rest(in_pop[0]), .in_pop_east(in_pop[1]), .in_pop_north(in_pop[2]),
    .in_pop_west(in_pop[3]), .in_pop_south(in_pop[4]),
    .in_pop_northeast(in_pop[5]), .in_pop_northwest(in_pop[6]),
    .in_pop_southwest(in_pop[7]), .in_pop_southeast(in_pop[8]),
    .in_is_solid(in_is_solid),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_post_rest(out_post[0]), .out_post_east(out_post[1]),
    .out_post_north(out_post[2]), .out_post_west(out_post[3]),
    .out_post_south(out_post[4]), .out_post_northeast(out_post[5]),
    .out_post_northwest(out_post[6]), .out_post_southwest(out_post[7]),
    .out_post_southeast(out_post[8]),
    .out_density(out_density), .out_velocity_x(out_velocity_x),
    .out_velocity_y(out_velocity_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && ((a < 0) != (b < 0))) q = q - 1;
    return q;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic relaxed_t collide(node_t n);
    relaxed_t r;
    longint rho, mx, my, ux, uy, uu, eu, poly, p, feq, wn, ex, ey, one;
    one = 64'sd1 << FRAC_BITS;
    rho = 0; mx = 0; my = 0; ux = 0; uy = 0;
    for (int k = 0; k < NDIR; k++) begin
      rho += n.pops[k];
      mx += dir_x(dir_idx_t'(k)) * longint'(n.pops[k]);
      my += dir_y(dir_idx_t'(k)) * longint'(n.pops[k]);
    end
    if (n.solid) begin
      r.post = n.pops;
      r.den = den_t'(clamp(one, 0, 262143));
      r.vx = '0;
      r.vy = '0;
      return r;
    end
    if (rho != 0) begin
      ux = clamp(floor_div((rho < 0 ? -mx : mx) * one, rho < 0 ? -rho : rho),
                 -65536, 65535);
      uy = clamp(floor_div((rho < 0 ? -my : my) * one, rho < 0 ? -rho : rho),
                 -65536, 65535);
    end
    uu = ux * ux + uy * uy;
    for (int k = 0; k < NDIR; k++) begin
      ex = dir_x(dir_idx_t'(k));
      ey = dir_y(dir_idx_t'(k));
      wn = (k == 0) ? 16 : (k < 5 ? 4 : 1);
      eu = ex * ux + ey * uy;
      poly = 2 * (one * one) + 6 * eu * one + 9 * eu * eu - 3 * uu;
      p = floor_div(poly, one * 2);
      feq = floor_div(wn * rho * p, 36 * one);
      r.post[k] = pop_t'(clamp(longint'(n.pops[k]) + floor_div(
        longint'(omega) * (feq - n.pops[k]), 64'sd1 << 16), -131072, 131071));
    end
    r.den = den_t'(clamp(rho, 0, 262143));
    r.vx = vel_t'(ux);
    r.vy = vel_t'(uy);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("Mismatch in %s: got %0d, expected %0d", field, got, want);
    errors++;
  endtask

  // Sender works in bursts; valid stays up until the item is taken.
  task automatic send_node(node_t n);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    for (int k = 0; k < NDIR; k++) in_pop[k] <= n.pops[k];
    in_is_solid <= n.solid;
    expected_q.push_back(collide(n));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_rate(rate_t value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    omega = value;
  endtask

  function automatic pop_t random_pop(int mode);
    case (mode)
      0: return pop_t'($urandom);
      1: return pop_t'($urandom_range(0, 20000));
      default: return pop_t'($urandom_range(6000, 9000));
    endcase
  endfunction

  function automatic node_t random_node(int mode);
    node_t n;
    for (int k = 0; k < NDIR; k++) n.pops[k] = random_pop(mode);
    n.solid = ($urandom_range(0, 9) == 0);
    return n;
  endfunction

  task automatic test_edges();
    node_t n;
    for (int k = 0; k < NDIR; k++) n.pops[k] = '0;
    n.solid = 0;
    send_node(n);
    n.solid = 1;
    send_node(n);
    for (int k = 0; k < NDIR; k++) n.pops[k] = 18'sd131071;
    n.solid = 0;
    send_node(n);
    n.solid = 1;
    send_node(n);
    for (int k = 0; k < NDIR; k++) n.pops[k] = -18'sd131072;
    n.solid = 0;
    send_node(n);
    for (int k = 0; k < NDIR; k++) n.pops[k] = 18'sd7282;
    send_node(n);
    for (int d = 1; d < NDIR; d++) begin
      for (int k = 0; k < NDIR; k++) n.pops[k] = '0;
      n.pops[d] = 18'sd131071;
      n.pops[(d + 2) % NDIR] = -18'sd65536;
      send_node(n);
    end
    for (int k = 0; k < NDIR; k++) n.pops[k] = (k % 2) ? 18'sd100 : -18'sd100;
    send_node(n);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_node(random_node($urandom_range(0, 2)));
  endtask

  task automatic test_backpressure();
    stall_mode = 1;
    hold_cycles = 80;
    for (int i = 0; i < 60; i++) send_node(random_node(2));
    wait_drained();
    stall_mode = 0;
  endtask

  always @(posedge clk) begin
    relaxed_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_q.pop_front();
        for (int k = 0; k < NDIR; k++)
          if (out_post[k] !== want.post[k])
            report_mismatch($sformatf("post[%0d]", k), out_post[k], want.post[k]);
        if (out_density !== want.den) report_mismatch("density", out_density, want.den);
        if (out_velocity_x !== want.vx)
          report_mismatch("velocity_x", out_velocity_x, want.vx);
        if (out_velocity_y !== want.vy)
          report_mismatch("velocity_y", out_velocity_y, want.vy);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (stall_mode) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edges();
    test_random(250);
    test_backpressure();
    write_rate(17'd0);
    test_edges();
    test_random(80);
    write_rate(17'd131071);
    test_edges();
    test_random(80);
    write_rate(17'd65536);
    test_random(80);
    write_rate(rate_t'($urandom));
    test_random(100);
    wait_drained();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
design/dbgk_pkg.sv
design/dbgk_div.sv
design/dbgk_lane.sv
design/d2q9_bgk_node_collision.sv
dv/d2q9_bgk_node_collision_test.sv
